### src/tcprto_pkg.sv
`default_nettype none

package tcprto_pkg;

  // configuration port shape
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [31:0] INIT_TIMEOUT_RST      = 32'd30000000;
  localparam logic [31:0] RTT_MIN_RST           = 32'd10000000;
  localparam logic [31:0] RTT_MAX_RST           = 32'd600000000;
  localparam logic [5:0]  BACKOFF_LIMIT_RST     = 6'd12;
  localparam logic [5:0]  MTU_PROBE_COUNT_RST   = 6'd2;
  localparam logic [5:0]  FIRST_RETRY_LIMIT_RST = 6'd3;
  localparam logic [31:0] GIVE_UP_TIME_RST      = 32'd1000000000;
  localparam logic [31:0] PERSIST_GIVE_UP_RST   = 32'd600000000;

  // event codes
  typedef enum logic [1:0] {
    FUNC_INIT   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_EXPIRE = 2'd2,
    FUNC_STOP   = 2'd3
  } func_t;

  // abort codes
  typedef enum logic [1:0] {
    ABORT_NONE      = 2'd0,
    ABORT_TIME_WAIT = 2'd1,
    ABORT_TIMEOUT   = 2'd2
  } abort_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_TIMEOUT      = 3'd0,
    CFG_RTT_MIN           = 3'd1,
    CFG_RTT_MAX           = 3'd2,
    CFG_BACKOFF_LIMIT     = 3'd3,
    CFG_MTU_PROBE_COUNT   = 3'd4,
    CFG_FIRST_RETRY_LIMIT = 3'd5,
    CFG_GIVE_UP_TIME      = 3'd6,
    CFG_PERSIST_GIVE_UP   = 3'd7
  } cfg_idx_t;

  // register file contents
  typedef struct packed {
    logic [31:0] init_timeout;
    logic [31:0] rtt_min;
    logic [31:0] rtt_max;
    logic [5:0]  backoff_limit;
    logic [5:0]  mtu_probe_count;
    logic [5:0]  first_retry_limit;
    logic [31:0] give_up_time;
    logic [31:0] persist_give_up;
  } cfg_t;

  // input item
  typedef struct packed {
    func_t       func;
    logic [31:0] rtt_sample;
    logic [31:0] elapsed_since_first;
    logic        persist_mode;
    logic        established_once;
    logic        in_time_wait;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [31:0] timeout_value;
    logic [5:0]  retry_count;
    abort_t      abort_code;
    logic        shrink_mss;
    logic        do_retransmit;
  } out_item_t;

endpackage

`default_nettype wire

### src/tcprto_cfg.sv
`default_nettype none

module tcprto_cfg
  import tcprto_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INIT_TIMEOUT:      cfg_nxt.init_timeout      = cfg_data;
        CFG_RTT_MIN:           cfg_nxt.rtt_min           = cfg_data;
        CFG_RTT_MAX:           cfg_nxt.rtt_max           = cfg_data;
        CFG_BACKOFF_LIMIT:     cfg_nxt.backoff_limit     = cfg_data[5:0];
        CFG_MTU_PROBE_COUNT:   cfg_nxt.mtu_probe_count   = cfg_data[5:0];
        CFG_FIRST_RETRY_LIMIT: cfg_nxt.first_retry_limit = cfg_data[5:0];
        CFG_GIVE_UP_TIME:      cfg_nxt.give_up_time      = cfg_data;
        CFG_PERSIST_GIVE_UP:   cfg_nxt.persist_give_up   = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_timeout      <= INIT_TIMEOUT_RST;
      cfg_r.rtt_min           <= RTT_MIN_RST;
      cfg_r.rtt_max           <= RTT_MAX_RST;
      cfg_r.backoff_limit     <= BACKOFF_LIMIT_RST;
      cfg_r.mtu_probe_count   <= MTU_PROBE_COUNT_RST;
      cfg_r.first_retry_limit <= FIRST_RETRY_LIMIT_RST;
      cfg_r.give_up_time      <= GIVE_UP_TIME_RST;
      cfg_r.persist_give_up   <= PERSIST_GIVE_UP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### src/tcprto_core.sv
`default_nettype none

module tcprto_core
  import tcprto_pkg::*;
#(
  parameter int TIME_BITS = 32
)
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_item_t  item,
  input  wire cfg_t      cfg,
  output out_item_t      result
);

  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] DEF_RST = TIME_BITS'(INIT_TIMEOUT_RST);

  // estimator state
  logic [TIME_BITS-1:0] srtt_r, srtt_nxt;
  logic [TIME_BITS-1:0] dev_r, dev_nxt;
  logic [TIME_BITS-1:0] cur_r, cur_nxt;
  logic [5:0]           retries_r, retries_nxt;

  // time-domain views of inputs and registers
  logic [TIME_BITS-1:0] rtt, init_tmo, lo, hi;
  assign rtt      = TIME_BITS'(item.rtt_sample);
  assign init_tmo = TIME_BITS'(cfg.init_timeout);
  assign lo       = TIME_BITS'(cfg.rtt_min);
  assign hi       = TIME_BITS'(cfg.rtt_max);

  // sample path: smoothing with gains 1/8 and 1/4
  logic                 rtt_ge;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] s_srtt, s_dev;
  logic [TIME_BITS+2:0] sum_w;
  logic [TIME_BITS-1:0] sum_sat, clamp_lo, s_rto;

  always_comb begin
    rtt_ge = (rtt >= srtt_r);
    diff   = rtt_ge ? (rtt - srtt_r) : (srtt_r - rtt);
    if (srtt_r != '0) begin
      s_srtt = rtt_ge ? (srtt_r + (diff >> 3)) : (srtt_r - (diff >> 3));
      s_dev  = (diff >= dev_r) ? (dev_r + ((diff - dev_r) >> 2))
                               : (dev_r - ((dev_r - diff) >> 2));
    end else begin
      // unseeded: first sample seeds both estimates
      s_srtt = rtt;
      s_dev  = rtt >> 1;
    end
    // srtt + 4*dev, saturating
    sum_w    = {3'b000, s_srtt} + {1'b0, s_dev, 2'b00};
    sum_sat  = (sum_w[TIME_BITS+2:TIME_BITS] != 3'b000) ? TMAX : sum_w[TIME_BITS-1:0];
    clamp_lo = (sum_sat < lo) ? lo : sum_sat;
    s_rto    = (clamp_lo > hi) ? hi : clamp_lo;
  end

  // expiry path: backoff and count
  logic [6:0]           cnt_inc;
  logic [5:0]           e_retries;
  logic [TIME_BITS-1:0] dbl, e_rto;
  logic                 e_shrink, e_abort;

  always_comb begin
    cnt_inc   = {1'b0, retries_r} + 7'd1;
    e_retries = (cnt_inc >= {1'b0, cfg.backoff_limit}) ? cfg.backoff_limit : cnt_inc[5:0];
    dbl       = cur_r[TIME_BITS-1] ? TMAX : {cur_r[TIME_BITS-2:0], 1'b0};
    e_rto     = (dbl > hi) ? hi : dbl;
    e_shrink  = 1'b0;
    e_abort   = 1'b0;
    if (!item.persist_mode) begin
      e_shrink = (cfg.mtu_probe_count == e_retries) && item.established_once;
      e_abort  = (e_retries > cfg.first_retry_limit) &&
                 (cfg.give_up_time <= item.elapsed_since_first);
    end else begin
      e_abort  = (cfg.persist_give_up <= item.elapsed_since_first);
    end
  end

  // event select
  always_comb begin
    srtt_nxt    = srtt_r;
    dev_nxt     = dev_r;
    cur_nxt     = cur_r;
    retries_nxt = retries_r;
    result.abort_code    = ABORT_NONE;
    result.shrink_mss    = 1'b0;
    result.do_retransmit = 1'b0;
    unique case (item.func)
      FUNC_INIT: begin
        srtt_nxt    = '0;
        dev_nxt     = init_tmo >> 2;
        cur_nxt     = init_tmo;
        retries_nxt = '0;
      end
      FUNC_SAMPLE: begin
        srtt_nxt    = s_srtt;
        dev_nxt     = s_dev;
        cur_nxt     = s_rto;
        retries_nxt = '0;
      end
      FUNC_STOP: begin
        retries_nxt = '0;
      end
      FUNC_EXPIRE: begin
        if (item.in_time_wait) begin
          result.abort_code = ABORT_TIME_WAIT;
        end else begin
          cur_nxt              = e_rto;
          retries_nxt          = e_retries;
          result.shrink_mss    = e_shrink;
          result.abort_code    = e_abort ? ABORT_TIMEOUT : ABORT_NONE;
          result.do_retransmit = !e_abort;
        end
      end
    endcase
    result.timeout_value = 32'(cur_nxt);
    result.retry_count   = retries_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r    <= '0;
      dev_r     <= DEF_RST >> 2;
      cur_r     <= DEF_RST;
      retries_r <= '0;
    end else if (fire) begin
      srtt_r    <= srtt_nxt;
      dev_r     <= dev_nxt;
      cur_r     <= cur_nxt;
      retries_r <= retries_nxt;
    end
  end

endmodule

`default_nettype wire

### src/tcp_rto_estimator_backoff.sv
`default_nettype none
// Retransmission timeout estimator with backoff for one connection.
// Input channel: in_valid / in_stall / in_item carry one event (init,
// round-trip sample, timer expiry or timer stop). Result channel:
// out_valid / out_stall / out_item carry one result per event: the
// timeout after the event, the retry count and the abort, MSS and
// retransmit flags. Registers are written on cfg_wr_en with cfg_index
// and cfg_data; the user must write them only while no event is in
// flight; the block itself does not enforce this. An accepted item
// sits in the input register, is processed and lands in the output
// register, which drives out_valid. Throughput is one item per cycle
// while the result channel is not stalled; the estimator state is
// updated by combinational logic between those two registers.
// A stalled result holds in the output register; the input register
// keeps taking items until it is full, then in_stall rises in the same
// cycle as out_stall. Reset (synchronous, rst_n low) empties both
// registers, loads the register defaults and sets the estimator to its
// init state.

module tcp_rto_estimator_backoff
  import tcprto_pkg::*;
#(
  parameter int TIME_BITS = 32
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  item_r;
  logic      item_vld_r, item_vld_nxt;
  out_item_t res_r;
  out_item_t result;
  logic      out_vld_r, out_vld_nxt;
  logic      advance;
  logic      fire;

  tcprto_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tcprto_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  // flow control
  assign advance  = !out_vld_r || !out_stall;
  assign fire     = item_vld_r && advance;
  assign in_stall = item_vld_r && !advance;

  always_comb begin
    item_vld_nxt = in_stall ? item_vld_r : in_valid;
    out_vld_nxt  = advance ? item_vld_r : out_vld_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = res_r;

endmodule

`default_nettype wire

### test/tb_tcp_rto_estimator_backoff.sv
`default_nettype none

module tb_tcp_rto_estimator_backoff;
  import tcprto_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam logic [31:0] TMAX  = 32'hFFFF_FFFF;

  // event flag sets: {persist_mode, established_once, in_time_wait}
  localparam logic [2:0] NO_FLAGS    = 3'b000;
  localparam logic [2:0] EST         = 3'b010;
  localparam logic [2:0] EST_TW      = 3'b011;
  localparam logic [2:0] PERSIST     = 3'b100;
  localparam logic [2:0] PERSIST_EST = 3'b110;

  // one line of the directed stimulus: a register write or an event
  typedef struct packed {
    logic        is_cfg;
    cfg_idx_t    reg_idx;
    logic [31:0] reg_val;
    in_item_t    ev;
    logic        typed;
    out_item_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  cfg_idx_t    cfg_index = CFG_INIT_TIMEOUT;
  logic [31:0] cfg_data = '0;

  // expectation travelling alongside the item, for rows with a typed result
  logic      row_typed = 1'b0;
  out_item_t row_want = '0;

  // predictor copy of the registers and estimator state
  cfg_t        shadow_cfg;
  logic [31:0] est_srtt;
  logic [31:0] est_rttvar;
  logic [31:0] est_rto;
  logic [5:0]  est_retries;

  out_item_t   pending_rto_results[$];
  stim_row_t   directed_rows[$];
  stim_row_t   init_row;
  int          events_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned sample_base = 1000;
  int unsigned elapsed_span = 3000000;
  cfg_t        phase_cfg;

  tcp_rto_estimator_backoff uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // estimator back to its post-init values
  function automatic void restart_estimator();
    est_retries = '0;
    est_srtt    = '0;
    est_rttvar  = shadow_cfg.init_timeout >> 2;
    est_rto     = shadow_cfg.init_timeout;
  endfunction

  // expected result of one event; advances the estimator state
  function automatic out_item_t rto_predict(in_item_t ev);
    out_item_t   res;
    logic [31:0] diff;
    logic [31:0] dbl;
    logic [34:0] sum;
    logic [6:0]  nxt;
    res = '0;
    case (ev.func)
      FUNC_INIT: begin
        restart_estimator();
      end
      FUNC_SAMPLE: begin
        if (est_srtt != 0) begin
          if (ev.rtt_sample >= est_srtt) begin
            diff = ev.rtt_sample - est_srtt;
            est_srtt = est_srtt + (diff >> 3);
          end else begin
            diff = est_srtt - ev.rtt_sample;
            est_srtt = est_srtt - (diff >> 3);
          end
          if (diff >= est_rttvar)
            est_rttvar = est_rttvar + ((diff - est_rttvar) >> 2);
          else
            est_rttvar = est_rttvar - ((est_rttvar - diff) >> 2);
        end else begin
          // unseeded: the sample seeds both estimates
          est_srtt   = ev.rtt_sample;
          est_rttvar = ev.rtt_sample >> 1;
        end
        est_retries = '0;
        // srtt + 4*dev, saturating, then clamped (max wins when bounds cross)
        sum = {3'b000, est_srtt} + {1'b0, est_rttvar, 2'b00};
        if (sum > {3'b000, TMAX}) sum = {3'b000, TMAX};
        est_rto = sum[31:0];
        if (est_rto < shadow_cfg.rtt_min) est_rto = shadow_cfg.rtt_min;
        if (est_rto > shadow_cfg.rtt_max) est_rto = shadow_cfg.rtt_max;
      end
      FUNC_STOP: begin
        est_retries = '0;
      end
      default: begin
        if (ev.in_time_wait) begin
          res.abort_code = ABORT_TIME_WAIT;
        end else begin
          nxt = {1'b0, est_retries} + 7'd1;
          if (nxt >= {1'b0, shadow_cfg.backoff_limit}) nxt = {1'b0, shadow_cfg.backoff_limit};
          est_retries = nxt[5:0];
          dbl = (est_rto > (TMAX >> 1)) ? TMAX : (est_rto << 1);
          if (dbl > shadow_cfg.rtt_max) dbl = shadow_cfg.rtt_max;
          est_rto = dbl;
          if (!ev.persist_mode) begin
            if (shadow_cfg.mtu_probe_count == est_retries && ev.established_once)
              res.shrink_mss = 1'b1;
            if (est_retries > shadow_cfg.first_retry_limit &&
                shadow_cfg.give_up_time <= ev.elapsed_since_first)
              res.abort_code = ABORT_TIMEOUT;
          end else if (shadow_cfg.persist_give_up <= ev.elapsed_since_first) begin
            res.abort_code = ABORT_TIMEOUT;
          end
          res.do_retransmit = (res.abort_code == ABORT_NONE);
        end
      end
    endcase
    res.timeout_value = est_rto;
    res.retry_count   = est_retries;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d (after %0d results)",
             what, got, want, results_seen);
    mismatches++;
  endtask

  // compare a delivered result with the oldest expectation
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_rto_results.size() == 0) begin
      report_mismatch("result with nothing outstanding", got.timeout_value, 0);
    end else begin
      want = pending_rto_results.pop_front();
      if (got.timeout_value !== want.timeout_value)
        report_mismatch("timeout_value", got.timeout_value, want.timeout_value);
      if (got.retry_count !== want.retry_count)
        report_mismatch("retry_count", 32'(got.retry_count), 32'(want.retry_count));
      if (got.abort_code !== want.abort_code)
        report_mismatch("abort_code", 32'(got.abort_code), 32'(want.abort_code));
      if (got.shrink_mss !== want.shrink_mss)
        report_mismatch("shrink_mss", 32'(got.shrink_mss), 32'(want.shrink_mss));
      if (got.do_retransmit !== want.do_retransmit)
        report_mismatch("do_retransmit", 32'(got.do_retransmit),
                        32'(want.do_retransmit));
    end
  endtask

  // monitor: register writes, accepted items and delivered results
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg = '{INIT_TIMEOUT_RST, RTT_MIN_RST, RTT_MAX_RST, BACKOFF_LIMIT_RST,
                     MTU_PROBE_COUNT_RST, FIRST_RETRY_LIMIT_RST, GIVE_UP_TIME_RST,
                     PERSIST_GIVE_UP_RST};
      restart_estimator();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_INIT_TIMEOUT:      shadow_cfg.init_timeout      = cfg_data;
          CFG_RTT_MIN:           shadow_cfg.rtt_min           = cfg_data;
          CFG_RTT_MAX:           shadow_cfg.rtt_max           = cfg_data;
          CFG_BACKOFF_LIMIT:     shadow_cfg.backoff_limit     = cfg_data[5:0];
          CFG_MTU_PROBE_COUNT:   shadow_cfg.mtu_probe_count   = cfg_data[5:0];
          CFG_FIRST_RETRY_LIMIT: shadow_cfg.first_retry_limit = cfg_data[5:0];
          CFG_GIVE_UP_TIME:      shadow_cfg.give_up_time      = cfg_data;
          CFG_PERSIST_GIVE_UP:   shadow_cfg.persist_give_up   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (row_typed) begin
          void'(rto_predict(in_item));
          pending_rto_results.push_back(row_want);
        end else begin
          pending_rto_results.push_back(rto_predict(in_item));
        end
      end
      if (out_valid && !out_stall) begin
        check_result(out_item);
        results_seen++;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic send_event(in_item_t ev, logic typed, out_item_t want);
    cfg_wr_en <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_item   <= ev;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (in_stall);
    events_sent++;
  endtask

  // stop sending until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_seen != events_sent) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_config(cfg_t c);
    write_reg(CFG_INIT_TIMEOUT, c.init_timeout);
    write_reg(CFG_RTT_MIN, c.rtt_min);
    write_reg(CFG_RTT_MAX, c.rtt_max);
    write_reg(CFG_BACKOFF_LIMIT, {26'd0, c.backoff_limit});
    write_reg(CFG_MTU_PROBE_COUNT, {26'd0, c.mtu_probe_count});
    write_reg(CFG_FIRST_RETRY_LIMIT, {26'd0, c.first_retry_limit});
    write_reg(CFG_GIVE_UP_TIME, c.give_up_time);
    write_reg(CFG_PERSIST_GIVE_UP, c.persist_give_up);
  endtask

  function automatic stim_row_t event_row(func_t f, logic [31:0] smp, logic [31:0] ela,
                                          logic [2:0] flags);
    stim_row_t r;
    r = '0;
    r.ev.func                = f;
    r.ev.rtt_sample          = smp;
    r.ev.elapsed_since_first = ela;
    r.ev.persist_mode        = flags[2];
    r.ev.established_once    = flags[1];
    r.ev.in_time_wait        = flags[0];
    return r;
  endfunction

  function automatic stim_row_t typed_row(stim_row_t r, logic [31:0] rto, logic [5:0] n,
                                          abort_t ab, logic shrink, logic rexmit);
    r.typed = 1'b1;
    r.want  = '{rto, n, ab, shrink, rexmit};
    return r;
  endfunction

  function automatic stim_row_t reg_row(cfg_idx_t idx, logic [31:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // mostly well-formed connection traffic, some fully random noise
  function automatic in_item_t random_event();
    in_item_t ev;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      ev.func                = func_t'($urandom_range(3));
      ev.rtt_sample          = $urandom;
      ev.elapsed_since_first = $urandom;
      ev.persist_mode        = 1'($urandom_range(1));
      ev.established_once    = 1'($urandom_range(1));
      ev.in_time_wait        = 1'($urandom_range(1));
    end else begin
      pick = $urandom_range(99);
      if (pick < 5)       ev.func = FUNC_INIT;
      else if (pick < 42) ev.func = FUNC_SAMPLE;
      else if (pick < 88) ev.func = FUNC_EXPIRE;
      else                ev.func = FUNC_STOP;
      pick = $urandom_range(19);
      if (pick == 0)      ev.rtt_sample = '0;
      else if (pick == 1) ev.rtt_sample = $urandom;
      else                ev.rtt_sample = sample_base / 2 + $urandom_range(0, sample_base);
      if ($urandom_range(3) == 0) ev.elapsed_since_first = $urandom;
      else                        ev.elapsed_since_first = $urandom_range(0, elapsed_span);
      ev.persist_mode     = ($urandom_range(3) == 0);
      ev.established_once = ($urandom_range(9) < 7);
      ev.in_time_wait     = ($urandom_range(9) == 0);
    end
    return ev;
  endfunction

  initial begin
    // directed part; reset registers until the first write
    directed_rows.push_back(typed_row(event_row(FUNC_STOP, 0, 0, NO_FLAGS),
                                      30000000, 0, ABORT_NONE, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_EXPIRE, 0, TMAX, EST_TW),
                                      30000000, 0, ABORT_TIME_WAIT, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_INIT, TMAX, 0, NO_FLAGS),
                                      30000000, 0, ABORT_NONE, 0, 0));
    // zero sample leaves it unseeded, timeout falls to the minimum
    directed_rows.push_back(typed_row(event_row(FUNC_SAMPLE, 0, 0, NO_FLAGS),
                                      10000000, 0, ABORT_NONE, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_SAMPLE, 1000000, 0, NO_FLAGS),
                                      10000000, 0, ABORT_NONE, 0, 0));
    // sum overflow saturates, then clamps to the maximum
    directed_rows.push_back(typed_row(event_row(FUNC_SAMPLE, TMAX, 0, NO_FLAGS),
                                      600000000, 0, ABORT_NONE, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_EXPIRE, 0, 0, EST),
                                      600000000, 1, ABORT_NONE, 0, 1));
    directed_rows.push_back(typed_row(event_row(FUNC_EXPIRE, 0, 0, EST),
                                      600000000, 2, ABORT_NONE, 1, 1));
    // count equal to R1: no give-up check
    directed_rows.push_back(typed_row(event_row(FUNC_EXPIRE, 0, TMAX, EST),
                                      600000000, 3, ABORT_NONE, 0, 1));
    directed_rows.push_back(typed_row(event_row(FUNC_EXPIRE, 0, TMAX, NO_FLAGS),
                                      600000000, 4, ABORT_TIMEOUT, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_EXPIRE, 0, 600000000, PERSIST_EST),
                                      600000000, 5, ABORT_TIMEOUT, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_EXPIRE, 0, 599999999, PERSIST),
                                      600000000, 6, ABORT_NONE, 0, 1));
    directed_rows.push_back(typed_row(event_row(FUNC_STOP, 0, 0, EST),
                                      600000000, 0, ABORT_NONE, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_INIT, 0, 0, NO_FLAGS),
                                      30000000, 0, ABORT_NONE, 0, 0));
    // crossed clamp bounds: maximum wins
    directed_rows.push_back(reg_row(CFG_RTT_MIN, TMAX));
    directed_rows.push_back(reg_row(CFG_RTT_MAX, 5));
    directed_rows.push_back(typed_row(event_row(FUNC_INIT, 0, 0, NO_FLAGS),
                                      30000000, 0, ABORT_NONE, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_SAMPLE, 1000, 0, NO_FLAGS),
                                      5, 0, ABORT_NONE, 0, 0));
    // doubling overflow, and a zero limit that pins the count
    directed_rows.push_back(reg_row(CFG_RTT_MIN, 1));
    directed_rows.push_back(reg_row(CFG_RTT_MAX, TMAX));
    directed_rows.push_back(reg_row(CFG_INIT_TIMEOUT, TMAX));
    directed_rows.push_back(reg_row(CFG_BACKOFF_LIMIT, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_INIT, 0, 0, NO_FLAGS),
                                      TMAX, 0, ABORT_NONE, 0, 0));
    directed_rows.push_back(typed_row(event_row(FUNC_EXPIRE, 0, 0, EST),
                                      TMAX, 0, ABORT_NONE, 0, 1));
    // aborts from the first retry on, MSS probe count of 5 never reached, then a persist give-up
    directed_rows.push_back(reg_row(CFG_BACKOFF_LIMIT, 63));
    directed_rows.push_back(reg_row(CFG_MTU_PROBE_COUNT, 5));
    directed_rows.push_back(reg_row(CFG_FIRST_RETRY_LIMIT, 0));
    directed_rows.push_back(reg_row(CFG_GIVE_UP_TIME, 0));
    directed_rows.push_back(reg_row(CFG_PERSIST_GIVE_UP, TMAX));
    directed_rows.push_back(reg_row(CFG_INIT_TIMEOUT, 1));
    directed_rows.push_back(typed_row(event_row(FUNC_INIT, 0, 0, NO_FLAGS),
                                      1, 0, ABORT_NONE, 0, 0));
    directed_rows.push_back(event_row(FUNC_SAMPLE, 3, 0, NO_FLAGS));
    repeat (4) directed_rows.push_back(event_row(FUNC_EXPIRE, 0, 0, EST));
    directed_rows.push_back(event_row(FUNC_EXPIRE, 0, TMAX, PERSIST_EST));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each with fresh registers and one of four idling patterns
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (phase == 1) begin
        phase_cfg = '{32'd1, 32'd1, 32'd1, 6'd1, 6'd0, 6'd0, 32'd0, 32'd0};
      end else if (phase == 6) begin
        phase_cfg = '{TMAX, TMAX, TMAX, 6'd63, 6'd63, 6'd63, TMAX, TMAX};
      end else if (phase == 3) begin
        phase_cfg = '{$urandom, $urandom, $urandom, 6'($urandom), 6'($urandom),
                      6'($urandom), $urandom, $urandom};
      end else begin
        phase_cfg.init_timeout      = $urandom_range(1, 1000000);
        phase_cfg.rtt_min           = $urandom_range(1, 50000);
        phase_cfg.rtt_max           = $urandom_range(50000, 4000000);
        phase_cfg.backoff_limit     = 6'($urandom_range(0, 15));
        phase_cfg.mtu_probe_count   = 6'($urandom_range(0, 15));
        phase_cfg.first_retry_limit = 6'($urandom_range(0, 15));
        phase_cfg.give_up_time      = $urandom_range(0, 3000000);
        phase_cfg.persist_give_up   = $urandom_range(0, 3000000);
      end
      write_config(phase_cfg);
      sample_base = $urandom_range(1, 200000);
      init_row = event_row(FUNC_INIT, 0, 0, NO_FLAGS);
      send_event(init_row.ev, 1'b0, '0);
      for (int k = 0; k < 85; k++) begin
        if ($urandom_range(199) == 0) wait_drained();
        send_event(random_event(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_rto_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_rto_results.size()), 0);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/tcprto_pkg.sv
src/tcprto_cfg.sv
src/tcprto_core.sv
src/tcp_rto_estimator_backoff.sv
test/tb_tcp_rto_estimator_backoff.sv
